// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for concurrent assertions on a clock with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/tsw_pkg.sv -----
// ----------------------------------------------------------------------------
// tsw_pkg
// Types and constants shared by the sensor window averaging block.
// ----------------------------------------------------------------------------
package tsw_pkg;

   localparam int HISTORY_DEPTH = 9;
   localparam int SAMPLE_W      = 13;
   localparam int BYTE_W        = 8;
   localparam int LSB_KEEP_W    = 5;
   localparam int WIN_W         = 4;
   localparam int DIGIT_W       = 4;
   localparam int HIST_IDX_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W         = SAMPLE_W + HIST_IDX_W + 1;
   localparam int MAG_W         = SUM_W - 1;
   localparam int STEP_W        = $clog2(MAG_W);
   localparam int FRAC_W        = 4;
   localparam int DEG_W         = SAMPLE_W - FRAC_W;

   localparam int CSR_ADDR_W    = 2;
   localparam int CSR_DATA_W    = 32;
   localparam int REG_WINDOW_SIZE = 0;

   localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_ABS,
      ST_DIV,
      ST_SIGN,
      ST_DONE
   } state_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type op;
   } alu_ctl_type;

endpackage

// ----- hw/rtl/tsw_alu.sv -----
// ----------------------------------------------------------------------------
// tsw_alu
// Shared adder/subtractor used for summing, negation and division steps.
// ----------------------------------------------------------------------------
module tsw_alu (
   input  tsw_pkg::alu_ctl_type          ctl,
   input  logic [tsw_pkg::SUM_W-1:0]     op_a,
   input  logic [tsw_pkg::SUM_W-1:0]     op_b,
   output logic [tsw_pkg::SUM_W-1:0]     result
);
   import tsw_pkg::*;

   always_comb begin
      case (ctl.op)
         ALU_ADD: result = op_a + op_b;
         ALU_SUB: result = op_a - op_b;
         default: result = op_a;
      endcase
   end

endmodule

// ----- hw/rtl/tsw_history.sv -----
// ----------------------------------------------------------------------------
// tsw_history
// Shift line of decoded samples, newest at entry 0, with one read port.
// ----------------------------------------------------------------------------
module tsw_history (
   input  logic                              clock,
   input  logic                              shift_en,
   input  logic [tsw_pkg::SAMPLE_W-1:0]      shift_data,
   input  logic [tsw_pkg::HIST_IDX_W-1:0]    rd_idx,
   output logic [tsw_pkg::SAMPLE_W-1:0]      rd_data
);
   import tsw_pkg::*;

   logic [SAMPLE_W-1:0] hist_ff [HISTORY_DEPTH];

   always_ff @(posedge clock) begin
      if (shift_en) begin
         hist_ff[0] <= shift_data;
         for (int i = 1; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= hist_ff[i-1];
         end
      end
   end

   assign rd_data = hist_ff[rd_idx];

endmodule

// ----- hw/rtl/tsw_digits.sv -----
// ----------------------------------------------------------------------------
// tsw_digits
// Decimal digits of a magnitude in 1/16 degree units.
// ----------------------------------------------------------------------------
module tsw_digits (
   input  logic [tsw_pkg::SAMPLE_W-1:0]  mag,
   output logic [tsw_pkg::DIGIT_W-1:0]   tens,
   output logic [tsw_pkg::DIGIT_W-1:0]   ones,
   output logic [tsw_pkg::DIGIT_W-1:0]   tenths
);
   import tsw_pkg::*;

   logic [DEG_W-1:0]   deg;
   logic [DEG_W-1:0]   deg_red;
   logic [6:0]         below_100;
   logic [14:0]        tens_prod;
   logic [7:0]         tenths_prod;
   logic [7:0]         tens_times_10;

   always_comb begin
      deg = mag[SAMPLE_W-1:FRAC_W];
      // The hundreds digit is dropped.
      if (deg >= 9'd200) begin
         deg_red = deg - 9'd200;
      end else if (deg >= 9'd100) begin
         deg_red = deg - 9'd100;
      end else begin
         deg_red = deg;
      end
      below_100 = deg_red[6:0];
      // x / 10 equals (x * 205) >> 11 for every x below 100.
      tens_prod     = {8'd0, below_100} * 15'd205;
      tens          = tens_prod[14:11];
      tens_times_10 = {4'd0, tens} * 8'd10;
      ones          = 4'(below_100 - tens_times_10[6:0]);
      // Tenths of the fraction only; whole degrees add multiples of ten.
      tenths_prod   = {4'd0, mag[FRAC_W-1:0]} * 8'd10;
      tenths        = tenths_prod[7:4];
   end

endmodule

// ----- hw/rtl/temp_sensor_window_average_top.sv -----
// ----------------------------------------------------------------------------
// temp_sensor_window_average_top
// Decodes sensor readings and averages the newest window_size samples.
// ----------------------------------------------------------------------------
// Usage: each item on the req_ channel is one two-byte sensor reading. It is
// decoded to 13 bits in 1/16 degree units and pushed into a nine-deep history.
// One result item on the rsp_ channel follows every request item. It carries
// the decoded sample, the current or held mean and its decimal digits.
// The mean is formed by one shared adder/subtractor: accumulation of the
// newest window_size samples, absolute value, 17 restoring-division steps and
// sign restore. A result is loaded into the output register from ST_DONE,
// reached straight from ST_IDLE when no mean is formed and after the mean
// states when one is; the next item is taken only once the result is loaded
// and the block is back in ST_IDLE.
// window_size is to be written through the csr_ port only while the block is idle; the block does not enforce this.
// Reset clears the history count, the held mean and window_size.
// When the receiver stalls, the finished item waits in the output register;
// the block still accepts one new item and holds its result until the
// output register is free.
module temp_sensor_window_average_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [tsw_pkg::BYTE_W-1:0]          req_msb_byte,
   input  logic [tsw_pkg::BYTE_W-1:0]          req_lsb_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [tsw_pkg::SAMPLE_W-1:0] rsp_new_sample,
   output logic                                rsp_average_valid,
   output logic signed [tsw_pkg::SAMPLE_W-1:0] rsp_average_value,
   output logic                                rsp_is_negative,
   output logic [tsw_pkg::DIGIT_W-1:0]         rsp_tens_digit,
   output logic [tsw_pkg::DIGIT_W-1:0]         rsp_ones_digit,
   output logic [tsw_pkg::DIGIT_W-1:0]         rsp_tenths_digit,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tsw_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [tsw_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [tsw_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   import tsw_pkg::*;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [WIN_W-1:0]        window_ff, window_in;
   logic [SUM_W-1:0]        acc_ff, acc_in;
   logic [HIST_IDX_W-1:0]   idx_ff, idx_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [WIN_W-1:0]        rem_ff, rem_in;
   logic [MAG_W-1:0]        dvd_ff, dvd_in;
   logic                    neg_ff, neg_in;
   logic                    mean_ff, mean_in;
   logic [SAMPLE_W-1:0]     sample_ff, sample_in;
   logic [SAMPLE_W-1:0]     held_avg_ff, held_avg_in;
   logic [SAMPLE_W-1:0]     held_mag_ff, held_mag_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]     rsp_sample_ff, rsp_sample_in;
   logic                    rsp_mean_ff, rsp_mean_in;
   logic [SAMPLE_W-1:0]     rsp_avg_ff, rsp_avg_in;
   logic [DIGIT_W-1:0]      rsp_tens_ff, rsp_tens_in;
   logic [DIGIT_W-1:0]      rsp_ones_ff, rsp_ones_in;
   logic [DIGIT_W-1:0]      rsp_tenths_ff, rsp_tenths_in;

   logic                    accept;
   logic                    cfg_write;
   logic [CNT_W-1:0]        count_next;
   logic [SAMPLE_W-1:0]     decoded;
   logic [SAMPLE_W-1:0]     hist_rd;
   logic [WIN_W:0]          trial;
   alu_ctl_type             alu_ctl;
   logic [SUM_W-1:0]        alu_a;
   logic [SUM_W-1:0]        alu_b;
   logic [SUM_W-1:0]        alu_res;
   logic [DIGIT_W-1:0]      dig_tens;
   logic [DIGIT_W-1:0]      dig_ones;
   logic [DIGIT_W-1:0]      dig_tenths;

   assign decoded    = {req_msb_byte, req_lsb_byte[BYTE_W-1 -: LSB_KEEP_W]};
   assign accept     = req_valid && req_ready;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign count_next = (int'(count_ff) < HISTORY_DEPTH) ? count_ff + 1'b1 : count_ff;
   assign trial      = {rem_ff, dvd_ff[MAG_W-1]};

   tsw_history u_history (
      .clock      (clock),
      .shift_en   (accept),
      .shift_data (decoded),
      .rd_idx     (idx_ff),
      .rd_data    (hist_rd)
   );

   tsw_alu u_alu (
      .ctl    (alu_ctl),
      .op_a   (alu_a),
      .op_b   (alu_b),
      .result (alu_res)
   );

   tsw_digits u_digits (
      .mag    (held_mag_ff),
      .tens   (dig_tens),
      .ones   (dig_ones),
      .tenths (dig_tenths)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         window_ff    <= '0;
         held_avg_ff  <= '0;
         held_mag_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         window_ff    <= window_in;
         held_avg_ff  <= held_avg_in;
         held_mag_ff  <= held_mag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff        <= acc_in;
      idx_ff        <= idx_in;
      step_ff       <= step_in;
      rem_ff        <= rem_in;
      dvd_ff        <= dvd_in;
      neg_ff        <= neg_in;
      mean_ff       <= mean_in;
      sample_ff     <= sample_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_mean_ff   <= rsp_mean_in;
      rsp_avg_ff    <= rsp_avg_in;
      rsp_tens_ff   <= rsp_tens_in;
      rsp_ones_ff   <= rsp_ones_in;
      rsp_tenths_ff <= rsp_tenths_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      window_in     = window_ff;
      acc_in        = acc_ff;
      idx_in        = idx_ff;
      step_in       = step_ff;
      rem_in        = rem_ff;
      dvd_in        = dvd_ff;
      neg_in        = neg_ff;
      mean_in       = mean_ff;
      sample_in     = sample_ff;
      held_avg_in   = held_avg_ff;
      held_mag_in   = held_mag_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_mean_in   = rsp_mean_ff;
      rsp_avg_in    = rsp_avg_ff;
      rsp_tens_in   = rsp_tens_ff;
      rsp_ones_in   = rsp_ones_ff;
      rsp_tenths_in = rsp_tenths_ff;
      req_ready     = 1'b0;
      alu_ctl.op    = ALU_ADD;
      alu_a         = acc_ff;
      alu_b         = {{(SUM_W-SAMPLE_W){hist_rd[SAMPLE_W-1]}}, hist_rd};

      if (cfg_write && csr_paddr == CSR_ADDR_W'(REG_WINDOW_SIZE * 4)) begin
         window_in = csr_pwdata[WIN_W-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               sample_in = decoded;
               count_in  = count_next;
               acc_in    = '0;
               idx_in    = '0;
               if (window_ff != '0 && int'(window_ff) <= HISTORY_DEPTH &&
                   int'(count_next) >= int'(window_ff)) begin
                  mean_in  = 1'b1;
                  state_in = ST_SUM;
               end else begin
                  mean_in  = 1'b0;
                  state_in = ST_DONE;
               end
            end
         end
         ST_SUM: begin
            alu_ctl.op = ALU_ADD;
            acc_in     = alu_res;
            idx_in     = idx_ff + 1'b1;
            if (int'(idx_ff) == int'(window_ff) - 1) begin
               state_in = ST_ABS;
            end
         end
         ST_ABS: begin
            alu_ctl.op = ALU_SUB;
            alu_a      = '0;
            alu_b      = acc_ff;
            neg_in     = acc_ff[SUM_W-1];
            dvd_in     = acc_ff[SUM_W-1] ? alu_res[MAG_W-1:0] : acc_ff[MAG_W-1:0];
            rem_in     = '0;
            step_in    = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            // Restoring division, one quotient bit per cycle.
            alu_ctl.op = ALU_SUB;
            alu_a      = {{(SUM_W-WIN_W-1){1'b0}}, trial};
            alu_b      = {{(SUM_W-WIN_W){1'b0}}, window_ff};
            if (!alu_res[SUM_W-1]) begin
               rem_in = alu_res[WIN_W-1:0];
            end else begin
               rem_in = trial[WIN_W-1:0];
            end
            dvd_in  = {dvd_ff[MAG_W-2:0], !alu_res[SUM_W-1]};
            step_in = step_ff + 1'b1;
            if (int'(step_ff) == MAG_W - 1) begin
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: begin
            alu_ctl.op  = ALU_SUB;
            alu_a       = '0;
            alu_b       = {{(SUM_W-MAG_W){1'b0}}, dvd_ff};
            held_mag_in = dvd_ff[SAMPLE_W-1:0];
            held_avg_in = neg_ff ? alu_res[SAMPLE_W-1:0] : dvd_ff[SAMPLE_W-1:0];
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = sample_ff;
               rsp_mean_in   = mean_ff;
               rsp_avg_in    = held_avg_ff;
               rsp_tens_in   = dig_tens;
               rsp_ones_in   = dig_ones;
               rsp_tenths_in = dig_tenths;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_new_sample    = rsp_sample_ff;
   assign rsp_average_valid = rsp_mean_ff;
   assign rsp_average_value = rsp_avg_ff;
   assign rsp_is_negative   = rsp_avg_ff[SAMPLE_W-1];
   assign rsp_tens_digit    = rsp_tens_ff;
   assign rsp_ones_digit    = rsp_ones_ff;
   assign rsp_tenths_digit  = rsp_tenths_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = {{(CSR_DATA_W-WIN_W){1'b0}}, window_ff};

endmodule

// ----- hw/rtl/tsw_checker.sv -----
// ----------------------------------------------------------------------------
// tsw_checker
// Port-level checks on the sensor window averaging block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tsw_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [tsw_pkg::SAMPLE_W-1:0] rsp_average_value,
   input logic                                rsp_is_negative,
   input logic [tsw_pkg::DIGIT_W-1:0]         rsp_tens_digit,
   input logic [tsw_pkg::DIGIT_W-1:0]         rsp_ones_digit,
   input logic [tsw_pkg::DIGIT_W-1:0]         rsp_tenths_digit,
   input logic                                csr_pready
);
   import tsw_pkg::*;

   // The block works on one item at a time.
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "ready right after an item was accepted")

   `ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_average_value), "result item dropped or changed while stalled")

   `ASSERT_NOW(a_sign_matches, clock, reset, rsp_valid, rsp_is_negative == rsp_average_value[SAMPLE_W-1], "sign flag disagrees with mean")

   `ASSERT_NOW(a_digits_decimal, clock, reset, rsp_valid, rsp_tens_digit <= DIGIT_MAX && rsp_ones_digit <= DIGIT_MAX && rsp_tenths_digit <= DIGIT_MAX, "digit out of decimal range")

   `ASSERT_NOW(a_pready_high, clock, reset, 1'b1, csr_pready, "register port not ready")

endmodule

bind temp_sensor_window_average_top tsw_checker u_tsw_checker (.*);
